// ----- hdl/wwm_pkg.sv -----
// Package for the weighted window median unit: widths, register indexes,
// status codes and the packed tile-store word.
// No dependencies.
package wwm_pkg;

	localparam int MAX_TILES    = 64;
	localparam int ADDR_W       = $clog2(MAX_TILES);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int DENSITY_BITS = 32;
	localparam int WEIGHT_BITS  = 16;
	localparam int WTOT_W       = WEIGHT_BITS + ADDR_W;
	localparam int FRAC_W       = 16;
	localparam int POS_W        = 38;
	localparam int BOUND_W      = 40;
	localparam int CMP_W        = 42;
	localparam int DEN_W        = 40;
	localparam int NUM_W        = 72;
	localparam int MUL_W        = 32;
	localparam int TILE_W       = DENSITY_BITS + WEIGHT_BITS;
	localparam int DIV_CNT_W    = $clog2(DENSITY_BITS + 1);

	typedef enum logic [2:0] {
		REG_CENTER     = 3'd0,
		REG_HALF_WIDTH = 3'd1,
		REG_SHIFT_LIM  = 3'd2,
		REG_FRAC_FLOOR = 3'd3,
		REG_SHIFT_GAIN = 3'd4,
		REG_FLOAT_EN   = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_TILES = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0]  weight;
		logic [DENSITY_BITS-1:0] density;
	} tile_t;

endpackage

// ----- hdl/wwm_ram.sv -----
// Tile store: one write port, one read port with registered read data.
// Depends on wwm_pkg.
module wwm_ram import wwm_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  tile_t             wdata,
	input  logic [ADDR_W-1:0] raddr,
	output tile_t             rdata
);
	tile_t mem_q [MAX_TILES];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/wwm_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on wwm_pkg.
module wwm_mul import wwm_pkg::*; (
	input  logic               clk,
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] p
);
	// register the product
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

// ----- hdl/wwm_div.sv -----
// Restoring divider, one quotient bit per cycle; quotient known to fit
// DENSITY_BITS. Depends on wwm_pkg.
module wwm_div import wwm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic [DENSITY_BITS-1:0] quot
);
	logic                    busy_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DENSITY_BITS-1:0] low_q;
	logic [DEN_W:0]          trial;
	logic                    fits;

	assign trial = {rem_q, low_q[DENSITY_BITS-1]};
	assign fits  = trial >= {1'b0, den};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DENSITY_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1 -: DEN_W];
			low_q <= num[DENSITY_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			low_q <= {low_q[DENSITY_BITS-2:0], 1'b0};
			quot  <= {quot[DENSITY_BITS-2:0], fits};
		end
	end
endmodule

// ----- hdl/weighted_window_median_unit.sv -----
// Top level of the weighted window median unit: tile insertion sequencer,
// window walk and result register. Depends on wwm_pkg, wwm_ram, wwm_mul, wwm_div.
//
//  channel  | direction | tdata                                   | tuser / tlast
//  s_axis   | in        | [31:0] tile_density [47:32] tile_weight | tuser: tile_valid
//           |           | [63:48] event_signal_fraction           | tlast: last_tile
//  m_axis   | out       | [31:0] density_estimate                 | tuser: status
//  cfg      | in        | cfg_data[15:0], cfg_index selects reg   | cfg_we
//
// One word at a time: s_axis_tready is high only while idle. A stored tile
// takes a read and compare step per stored tile compared (each one moved
// aside and the one that stops the scan; none when the store is empty),
// then a place step. A last word then returns to idle with no tiles, else
// runs setup, a compare and an accumulate step per tile walked (shared
// multiplier), the empty check and the divider. A result waiting on
// m_axis_tready does not block input; the next last word holds in its first step until that result is taken.
// Reset clears tile count, weight total, control and configuration registers;
// the tile RAM is not cleared, only entries below the count are read.
module weighted_window_median_unit import wwm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // density, weight, signal fraction
	input  logic        s_axis_tuser,  // tile_valid
	input  logic        s_axis_tlast,  // last_tile
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // density_estimate
	output logic [1:0]  m_axis_tuser,  // status
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_INS_RD = 14'b00000000000010,
		S_INS_CM = 14'b00000000000100,
		S_INS_PT = 14'b00000000001000,
		S_FIN    = 14'b00000000010000,
		S_SH_MUL = 14'b00000000100000,
		S_SH_FIN = 14'b00000001000000,
		S_LO_MUL = 14'b00000010000000,
		S_HI_MUL = 14'b00000100000000,
		S_WK_INI = 14'b00001000000000,
		S_WK_CMP = 14'b00010000000000,
		S_WK_ACC = 14'b00100000000000,
		S_DCHK   = 14'b01000000000000,
		S_DIV    = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic   out_q;

	// configuration registers
	logic [FRAC_W-1:0] center_q, half_q, limit_q, floor_q, gain_q;
	logic              float_q;

	// event state
	logic [CNT_W-1:0]        count_q, pos_q, idx_q;
	logic [WTOT_W-1:0]       wtot_q;
	logic [DENSITY_BITS-1:0] d_q;
	logic [WEIGHT_BITS-1:0]  w_q;
	logic [FRAC_W-1:0]       sf_q;
	logic                    last_q;

	// walk state
	logic [FRAC_W-1:0]  cl_q;
	logic [FRAC_W+1:0]  ch_q;
	logic [BOUND_W-1:0] lo_q, hi_q;
	logic [POS_W-1:0]   ps_q;
	logic [DEN_W-1:0]   den_q;
	logic [NUM_W-1:0]   num_q;
	logic               inside_q, add_q, clr_q, stop_q;

	// result
	logic [DENSITY_BITS-1:0] dens_q;
	status_t                 stat_q;

	// shared units
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	tile_t             wdata, rdata;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [2*MUL_W-1:0] mul_p;
	logic              div_start, div_done;
	logic [DENSITY_BITS-1:0] div_q;

	wwm_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);
	wwm_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(mul_p));
	wwm_div u_div (.clk, .arst_n, .start(div_start), .num(num_q), .den(den_q),
		.done(div_done), .quot(div_q));

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_q;
	assign m_axis_tdata  = dens_q;
	assign m_axis_tuser  = stat_q;

	// insertion compare: stored tile sorts after the new one
	logic greater;
	assign greater = (rdata.density > d_q) ||
		(rdata.density == d_q && rdata.weight > w_q);

	// shift computation from the registered product
	logic [FRAC_W-1:0] excess, s_lim;
	logic [19:0]       s_raw;
	logic signed [FRAC_W:0] diff;
	assign excess = (sf_q > floor_q) ? FRAC_W'(sf_q - floor_q) : '0;
	assign s_raw  = mul_p[31:12];
	assign s_lim  = (s_raw > 20'(limit_q)) ? limit_q : s_raw[FRAC_W-1:0];
	assign diff   = $signed({1'b0, center_q}) - $signed({1'b0, half_q});

	// window walk compare
	logic [MUL_W-1:0]       f;
	logic signed [CMP_W-1:0] rs, rt, fs, ps_s;
	logic lt_s, lt_t, rt_pos;
	assign f      = {rdata.weight, 16'b0};
	assign fs     = $signed({10'b0, f});
	assign ps_s   = $signed({4'b0, ps_q});
	assign rs     = $signed({2'b0, lo_q}) - ps_s;
	assign rt     = $signed({2'b0, hi_q}) - ps_s;
	assign lt_s   = rs < fs;
	assign lt_t   = rt < fs;
	assign rt_pos = rt > $signed(CMP_W'(0));

	// shared unit steering
	always_comb begin
		we        = 1'b0;
		waddr     = pos_q[ADDR_W-1:0];
		wdata     = rdata;
		raddr     = idx_q[ADDR_W-1:0];
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_INS_RD: raddr = ADDR_W'(pos_q - CNT_W'(1));
			S_INS_CM: we = greater;
			S_INS_PT: begin
				we    = 1'b1;
				wdata = '{weight: w_q, density: d_q};
			end
			S_SH_MUL: begin
				mul_a = float_q ? MUL_W'(excess) : '0;
				mul_b = MUL_W'(gain_q);
			end
			S_LO_MUL: begin
				mul_a = MUL_W'(cl_q);
				mul_b = MUL_W'(wtot_q);
			end
			S_HI_MUL: begin
				mul_a = MUL_W'(ch_q);
				mul_b = MUL_W'(wtot_q);
			end
			S_WK_INI: raddr = '0;
			S_WK_CMP: begin
				mul_a = rdata.density;
				if (lt_s && !inside_q) begin
					mul_b = MUL_W'(fs - rs);
				end else if (lt_t) begin
					mul_b = MUL_W'(rt);
				end else begin
					mul_b = f;
				end
			end
			S_DCHK: div_start = (den_q != '0);
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 16'd32768;
			half_q   <= 16'd6554;
			limit_q  <= '0;
			floor_q  <= '0;
			gain_q   <= '0;
			float_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CENTER:     center_q <= cfg_data;
				REG_HALF_WIDTH: half_q   <= cfg_data;
				REG_SHIFT_LIM:  limit_q  <= cfg_data;
				REG_FRAC_FLOOR: floor_q  <= cfg_data;
				REG_SHIFT_GAIN: gain_q   <= cfg_data;
				REG_FLOAT_EN:   float_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			out_q    <= 1'b0;
			count_q  <= '0;
			wtot_q   <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			last_q   <= 1'b0;
			inside_q <= 1'b0;
			add_q    <= 1'b0;
			clr_q    <= 1'b0;
			stop_q   <= 1'b0;
		end else begin
			// drain the result word
			if (out_q && m_axis_tready) begin
				out_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// take the next word
					if (accept) begin
						last_q <= s_axis_tlast;
						if (s_axis_tuser && count_q < CNT_W'(MAX_TILES)) begin
							wtot_q  <= wtot_q + WTOT_W'(s_axis_tdata[47:32]);
							pos_q   <= count_q;
							state_q <= (count_q == '0) ? S_INS_PT : S_INS_RD;
						end else if (s_axis_tlast) begin
							state_q <= S_FIN;
						end
					end
				end
				S_INS_RD: state_q <= S_INS_CM;
				S_INS_CM: begin
					// move the stored tile up one slot or place the new one
					if (greater) begin
						pos_q   <= pos_q - CNT_W'(1);
						state_q <= (pos_q == CNT_W'(1)) ? S_INS_PT : S_INS_RD;
					end else begin
						state_q <= S_INS_PT;
					end
				end
				S_INS_PT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					// hold until the previous result word is taken
					if (!out_q) begin
						state_q <= (count_q == '0) ? S_IDLE : S_SH_MUL;
					end
				end
				S_SH_MUL: state_q <= S_SH_FIN;
				S_SH_FIN: state_q <= S_LO_MUL;
				S_LO_MUL: state_q <= S_HI_MUL;
				S_HI_MUL: state_q <= S_WK_INI;
				S_WK_INI: begin
					idx_q    <= '0;
					inside_q <= 1'b0;
					state_q  <= S_WK_CMP;
				end
				S_WK_CMP: begin
					// classify the tile against the window bounds
					stop_q <= (idx_q + CNT_W'(1) == count_q);
					if (lt_s && !inside_q) begin
						add_q    <= 1'b1;
						clr_q    <= 1'b1;
						inside_q <= 1'b1;
						if (lt_t) stop_q <= 1'b1;
					end else if (lt_t) begin
						add_q  <= rt_pos;
						clr_q  <= 1'b0;
						stop_q <= 1'b1;
					end else begin
						add_q <= inside_q;
						clr_q <= 1'b0;
					end
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= S_WK_ACC;
				end
				S_WK_ACC: state_q <= stop_q ? S_DCHK : S_WK_CMP;
				S_DCHK: begin
					// walk done: empty the store for the next event
					count_q <= '0;
					wtot_q  <= '0;
					if (den_q == '0) begin
						out_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						out_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// no-tiles result
			if (state_q == S_FIN && count_q == '0 && !out_q) begin
				out_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q  <= s_axis_tdata[31:0];
			w_q  <= s_axis_tdata[47:32];
			sf_q <= s_axis_tdata[63:48];
		end
		unique case (state_q)
			S_FIN: begin
				if (!out_q) begin
					dens_q <= '0;
					stat_q <= ST_NO_TILES;
				end
			end
			S_SH_FIN: begin
				// lower window edge, never below zero
				if (diff < 0 || 17'(s_lim) > diff[FRAC_W:0]) begin
					cl_q <= '0;
					ch_q <= {1'b0, half_q, 1'b0};
				end else begin
					cl_q <= FRAC_W'(diff[FRAC_W-1:0] - s_lim);
					ch_q <= 18'(diff[FRAC_W-1:0] - s_lim) + {1'b0, half_q, 1'b0};
				end
			end
			S_HI_MUL: lo_q <= mul_p[BOUND_W-1:0];
			S_WK_INI: begin
				hi_q  <= mul_p[BOUND_W-1:0];
				ps_q  <= '0;
				den_q <= '0;
				num_q <= '0;
			end
			S_WK_CMP: begin
				ps_q <= ps_q + POS_W'(f);
				if (lt_s && !inside_q) begin
					den_q <= DEN_W'(fs - rs);
				end else if (lt_t) begin
					if (rt_pos) den_q <= den_q + DEN_W'(rt);
				end else if (inside_q) begin
					den_q <= den_q + DEN_W'(f);
				end
			end
			S_WK_ACC: begin
				num_q <= (clr_q ? '0 : num_q) + (add_q ? NUM_W'(mul_p) : '0);
			end
			S_DCHK: begin
				dens_q <= '0;
				stat_q <= ST_EMPTY;
			end
			S_DIV: begin
				dens_q <= div_q;
				stat_q <= ST_OK;
			end
			default: ;
		endcase
	end
endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for weighted_window_median_unit: drives tile words with
// random gaps, predicts each event's window average and compares results.
// Depends on wwm_pkg and the unit's RTL.
module testbench import wwm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        last;
		logic        valid;
		logic [63:0] data;
	} word_t;

	typedef struct packed {
		logic [31:0] estimate;
		logic [1:0]  status;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	weighted_window_median_unit uut (.*);

	// predictor state
	logic [31:0] tile_dens [MAX_TILES];
	logic [15:0] tile_wt [MAX_TILES];
	int unsigned n_tiles;
	longint unsigned wt_sum;
	logic [15:0] regs [6];

	word_t    pending_words[$];
	outcome_t expected_results[$];
	int       errors;
	int       results_seen;
	int       idle_cycles;
	int       send_wait, recv_wait;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// predict the result of one accepted word, if any
	task automatic predict_word(input word_t wd);
		logic [31:0] d;
		logic [15:0] w;
		longint c0, h, s, c, lo, hi, part, f, rs, rt, ex;
		logic [127:0] num;
		logic [63:0] den;
		logic [127:0] q;
		bit in_win;
		int pos;
		outcome_t r;
		d = wd.data[31:0];
		w = wd.data[47:32];
		if (wd.valid && n_tiles < MAX_TILES) begin
			pos = n_tiles;
			while (pos > 0 && (tile_dens[pos-1] > d ||
					(tile_dens[pos-1] == d && tile_wt[pos-1] > w))) begin
				tile_dens[pos] = tile_dens[pos-1];
				tile_wt[pos] = tile_wt[pos-1];
				pos--;
			end
			tile_dens[pos] = d;
			tile_wt[pos] = w;
			n_tiles++;
			wt_sum += w;
		end
		if (!wd.last)
			return;
		r = '0;
		if (n_tiles == 0) begin
			r.status = ST_NO_TILES;
		end else begin
			c0 = regs[REG_CENTER];
			h = regs[REG_HALF_WIDTH];
			s = 0;
			if (regs[REG_FLOAT_EN][0]) begin
				ex = wd.data[63:48] > regs[REG_FRAC_FLOOR] ?
					longint'(wd.data[63:48]) - regs[REG_FRAC_FLOOR] : 0;
				s = (ex * regs[REG_SHIFT_GAIN]) >>> 12;
			end
			if (s > regs[REG_SHIFT_LIM])
				s = regs[REG_SHIFT_LIM];
			if (s > c0 - h)
				s = c0 - h;
			c = c0 - s;
			lo = (c - h) * longint'(wt_sum);
			hi = (c + h) * longint'(wt_sum);
			part = 0;
			num = 0;
			den = 0;
			in_win = 0;
			for (int i = 0; i < n_tiles; i++) begin
				f = longint'(tile_wt[i]) << 16;
				rs = lo - part;
				rt = hi - part;
				if (rs < f && !in_win) begin
					num = tile_dens[i] * (f - rs);
					den = f - rs;
					in_win = 1;
					if (rt < f)
						break;
				end else if (rt < f) begin
					if (rt > 0) begin
						num += tile_dens[i] * rt;
						den += rt;
					end
					break;
				end else if (in_win) begin
					num += tile_dens[i] * f;
					den += f;
				end
				part += f;
			end
			if (den == 0) begin
				r.status = ST_EMPTY;
			end else begin
				q = num / den;
				r.estimate = q[31:0];
				r.status = ST_OK;
			end
		end
		expected_results.push_back(r);
		n_tiles = 0;
		wt_sum = 0;
	endtask

	// drive words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 0;
			s_axis_tlast <= 0;
			send_wait <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				predict_word('{s_axis_tlast, s_axis_tuser, s_axis_tdata});
			if (send_wait > 0 || pending_words.size() == 0) begin
				s_axis_tvalid <= 0;
				if (send_wait > 0)
					send_wait <= send_wait - 1;
			end else begin
				word_t wd;
				wd = pending_words.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tdata <= wd.data;
				s_axis_tuser <= wd.valid;
				s_axis_tlast <= wd.last;
				send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			end
		end
	end

	// accept results with random stalls and check them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			recv_wait <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				outcome_t e;
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result est=%h status=%0d", $time,
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (e.estimate !== m_axis_tdata || e.status !== m_axis_tuser) begin
						$display("%0t: mismatch expected est=%h status=%0d actual est=%h status=%0d",
							$time, e.estimate, e.status, m_axis_tdata, m_axis_tuser);
						errors++;
					end
				end
				recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				m_axis_tready <= 0;
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// watchdog: count cycles with no word moving either way
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic word_t make_tile(logic [31:0] d, logic [15:0] w, bit v, bit l,
			logic [15:0] sf);
		return '{l, v, {sf, w, d}};
	endfunction

	// random density, often colliding to exercise tie ordering
	function automatic logic [31:0] rand_density();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// queue one event of n tiles plus a closing last word
	task automatic queue_event(int n);
		for (int i = 0; i < n; i++)
			pending_words.push_back(make_tile(rand_density(), rand_weight(),
				$urandom_range(0, 9) != 0, 0, $urandom));
		pending_words.push_back(make_tile(rand_density(), rand_weight(),
			$urandom_range(0, 1), 1, $urandom));
	endtask

	task automatic wait_drained();
		wait (pending_words.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		regs[idx] = (idx == REG_FLOAT_EN) ? {15'd0, val[0]} : val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int count;
		errors = 0;
		results_seen = 0;
		idle_cycles = 0;
		n_tiles = 0;
		wt_sum = 0;
		regs[REG_CENTER] = 16'd32768;
		regs[REG_HALF_WIDTH] = 16'd6554;
		regs[REG_SHIFT_LIM] = 0;
		regs[REG_FRAC_FLOOR] = 0;
		regs[REG_SHIFT_GAIN] = 0;
		regs[REG_FLOAT_EN] = 0;
		cfg_we = 0;
		cfg_index = REG_CENTER;
		cfg_data = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: no tiles, extremes, ties, last with valid, empty window
		pending_words.push_back(make_tile(0, 0, 0, 1, 0));
		pending_words.push_back(make_tile(32'hFFFF_FFFF, 16'hFFFF, 1, 0, 0));
		pending_words.push_back(make_tile(0, 16'hFFFF, 1, 0, 16'hFFFF));
		pending_words.push_back(make_tile(5, 7, 1, 0, 0));
		pending_words.push_back(make_tile(5, 3, 1, 1, 16'hFFFF));
		pending_words.push_back(make_tile(9, 0, 1, 0, 0));
		pending_words.push_back(make_tile(9, 0, 1, 1, 0));
		pending_words.push_back(make_tile(7, 100, 1, 1, 0));
		wait_drained();
		// directed: overfill the store so later tiles are dropped
		for (int i = 0; i < MAX_TILES + 3; i++)
			pending_words.push_back(make_tile($urandom, $urandom, 1, 0, 0));
		pending_words.push_back(make_tile(1, 1, 1, 1, 0));
		wait_drained();
		// zero-width window just below the total weight
		write_reg(REG_CENTER, 16'hFFFF);
		write_reg(REG_HALF_WIDTH, 0);
		pending_words.push_back(make_tile(3, 10, 1, 1, 0));
		wait_drained();

		// random phases, each under a new register setting
		count = 0;
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_CENTER, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF : $urandom);
			write_reg(REG_HALF_WIDTH, ph == 2 ? 16'hFFFF : ph == 3 ? 16'd0 :
				$urandom_range(0, 20000));
			write_reg(REG_SHIFT_LIM, ph == 4 ? 16'hFFFF : $urandom);
			write_reg(REG_FRAC_FLOOR, ph == 5 ? 16'hFFFF : ph == 6 ? 16'd0 : $urandom);
			write_reg(REG_SHIFT_GAIN, ph == 7 ? 16'hFFFF : ph == 8 ? 16'd0 : $urandom);
			write_reg(REG_FLOAT_EN, ph % 3 != 0);
			while (count < (ph + 1) * 90) begin
				int n;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) :
					$urandom_range(0, 8);
				queue_event(n);
				count += n + 1;
			end
			wait_drained();
		end

		$display("Covered %0d results over directed events and 12 register settings.",
			results_seen);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
